// ===== hdl/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types, constants and helpers for the number to ascii formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package nta_pkg;

   // format selector codes
   typedef enum logic [1:0] {
      FMT_UDEC = 2'd0,
      FMT_SDEC = 2'd1,
      FMT_HEX  = 2'd2,
      FMT_Q16  = 2'd3
   } fmt_type;

   localparam int unsigned DigitDepth = 10;
   localparam int unsigned CountWidth = $clog2(DigitDepth + 1);

   // divide by ten as multiply by reciprocal, then shift
   localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;
   localparam int unsigned QuotWidth = 29;

   localparam logic [13:0] FracScale = 14'd10000;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_DOT   = 7'h2E;
   localparam logic [6:0] CHAR_X     = 7'h78;
   localparam logic [6:0] CHAR_HEXA  = 7'h37;

   // source of the character loaded into the output word
   typedef enum logic [2:0] {
      SEL_MINUS,
      SEL_DOT,
      SEL_ZERO,
      SEL_X,
      SEL_DIGIT,
      SEL_HEX
   } char_sel_type;

   typedef struct packed {
      logic         load;
      logic         mul;
      logic         div;
      logic         frac;
      logic         emit;
      char_sel_type sel;
      logic         last;
   } nta_cmd_type;

   typedef struct packed {
      fmt_type               func;
      logic                  neg;
      logic                  q_zero;
      logic [CountWidth-1:0] count;
   } nta_status_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] base;
      base = (nib > 4'd9) ? CHAR_HEXA : CHAR_ZERO;
      return base + {3'b000, nib};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/nta_req_if.sv =====
// ----------------------------------------------------------------------------
// nta_req_if
// Request channel: format selector and 32-bit value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface nta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/nta_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nta_rsp_if
// Response channel: one ascii character per word with a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface nta_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] text_char;
   logic       last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== hdl/nta_datapath.sv =====
// ----------------------------------------------------------------------------
// nta_datapath
// Magnitude, divide-by-ten digit extraction, digit store and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module nta_datapath
   import nta_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [1:0]     req_func,
   input  wire logic [31:0]    req_value,
   input  wire nta_cmd_type    cmd,
   output nta_status_type      status,
   output logic [6:0]          rsp_text_char,
   output logic                rsp_last_char
);

   fmt_type               func_ff, func_in;
   logic                  neg_ff, neg_in;
   logic [15:0]           frac_ff, frac_in;
   logic [31:0]           work_ff, work_in;
   logic [QuotWidth-1:0]  quot_ff, quot_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [3:0]            digit_store_ff [DigitDepth];
   logic [6:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic [31:0]           mag;
   logic                  req_neg;
   logic [63:0]           prod;
   logic [29:0]           frac_prod;
   logic [3:0]            rem;
   logic [CountWidth-1:0] rd_idx;
   logic [3:0]            rd_digit;

   always_comb begin
      req_neg   = req_func[0] & req_value[31];
      mag       = req_neg ? (32'd0 - req_value) : req_value;
      prod      = 64'(work_ff) * 64'(Recip10);
      frac_prod = 30'(frac_ff) * 30'(FracScale);
      rem       = work_ff[3:0] - 4'(quot_ff[3:0] * 4'd10);
      rd_idx    = count_ff - CountWidth'(1);
      rd_digit  = digit_store_ff[rd_idx];
   end

   always_comb begin
      func_in  = func_ff;
      neg_in   = neg_ff;
      frac_in  = frac_ff;
      work_in  = work_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         func_in  = fmt_type'(req_func);
         neg_in   = req_neg;
         frac_in  = mag[15:0];
         work_in  = (fmt_type'(req_func) == FMT_Q16) ? {16'd0, mag[31:16]} : mag;
         count_in = '0;
      end
      if (cmd.mul) begin
         quot_in = prod[63:63-QuotWidth+1];
      end
      if (cmd.div) begin
         work_in  = 32'(quot_ff);
         count_in = count_ff + CountWidth'(1);
      end
      if (cmd.frac) begin
         work_in  = {18'd0, frac_prod[29:16]};
         count_in = '0;
      end
      if (cmd.emit) begin
         last_in = cmd.last;
         case (cmd.sel)
            SEL_MINUS: char_in = CHAR_MINUS;
            SEL_DOT:   char_in = CHAR_DOT;
            SEL_ZERO:  char_in = CHAR_ZERO;
            SEL_X:     char_in = CHAR_X;
            SEL_DIGIT: begin
               char_in  = CHAR_ZERO + {3'b000, rd_digit};
               count_in = rd_idx;
            end
            SEL_HEX: begin
               char_in  = hex_char(work_ff[31:28]);
               work_in  = {work_ff[27:0], 4'd0};
               count_in = count_ff + CountWidth'(1);
            end
            default: char_in = CHAR_ZERO;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         work_ff  <= '0;
      end else begin
         count_ff <= count_in;
         work_ff  <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      neg_ff  <= neg_in;
      frac_ff <= frac_in;
      quot_ff <= quot_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (cmd.div) begin
         digit_store_ff[count_ff] <= rem;
      end
   end

   assign status.func   = func_ff;
   assign status.neg    = neg_ff;
   assign status.q_zero = (quot_ff == '0);
   assign status.count  = count_ff;

   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

`default_nettype wire

// ===== hdl/nta_controller.sv =====
// ----------------------------------------------------------------------------
// nta_controller
// Sequencer for sign, digit extraction, prefix and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module nta_controller
   import nta_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire nta_status_type status,
   output nta_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SIGN,
      ST_MUL,
      ST_DIV,
      ST_DIGITS,
      ST_DOT,
      ST_FRAC,
      ST_PFX0,
      ST_PFXX,
      ST_HEX
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      frac_phase_ff, frac_phase_in;
   logic      slot_free;

   localparam logic [CountWidth-1:0] CountOne   = CountWidth'(1);
   localparam logic [CountWidth-1:0] CountFrac  = CountWidth'(3);
   localparam logic [CountWidth-1:0] CountHexLs = CountWidth'(7);

   always_comb begin
      slot_free     = !valid_ff || rsp_ready;
      state_in      = state_ff;
      frac_phase_in = frac_phase_ff;
      cmd           = '0;
      cmd.sel       = SEL_ZERO;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load      = 1'b1;
               frac_phase_in = 1'b0;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.func == FMT_HEX) begin
               state_in = ST_PFX0;
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_MINUS;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (frac_phase_ff) begin
               state_in = (status.count == CountFrac) ? ST_DIGITS : ST_MUL;
            end else begin
               state_in = status.q_zero ? ST_DIGITS : ST_MUL;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_DIGIT;
               cmd.last = (status.count == CountOne) &&
                          (frac_phase_ff || status.func != FMT_Q16);
               if (status.count == CountOne) begin
                  if (status.func == FMT_Q16 && !frac_phase_ff) begin
                     state_in = ST_DOT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_DOT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_DOT;
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            cmd.frac      = 1'b1;
            frac_phase_in = 1'b1;
            state_in      = ST_MUL;
         end
         ST_PFX0: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_ZERO;
               state_in = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_X;
               state_in = ST_HEX;
            end
         end
         ST_HEX: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_HEX;
               cmd.last = (status.count == CountHexLs);
               if (status.count == CountHexLs) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= 1'b0;
         frac_phase_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         frac_phase_ff <= frac_phase_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/number_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats a 32-bit value as ascii text, one character per response word.
//
// req_port carries func (0 unsigned decimal, 1 signed decimal, 2 hex with
// 0x prefix, 3 signed Q16.16) and value. One value is taken at a time;
// req_port.ready is high while the sequencer is idle.
// rsp_port returns the text one character per word, last_char set on the
// final character. The character sits in an output register, so the next
// value is accepted while the final character still waits to be taken.
// Decimal digits come from a shared divide-by-ten unit, each digit by a
// reciprocal multiply and then a remainder and store. The first character
// is the 0x prefix for hex and the minus sign for negative values, else
// the leading digit once all digits are stored. Q16.16 text is the integer
// digits, the dot, then the fraction digits.
// A stalled receiver holds the sequencer only in states that emit a character.
// Synchronous reset returns the sequencer to idle and drops rsp valid.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_ascii_formatter
   import nta_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   nta_req_if.sink    req_port,
   nta_rsp_if.source  rsp_port
);

   nta_cmd_type    cmd;
   nta_status_type status;

   nta_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nta_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_port.func),
      .req_value     (req_port.value),
      .cmd           (cmd),
      .status        (status),
      .rsp_text_char (rsp_port.text_char),
      .rsp_last_char (rsp_port.last_char)
   );

endmodule

`default_nettype wire
